### rtl/tdr_pkg.sv
// Shared types, widths and constants for the triangle depth rasterizer.
package tdr_pkg;

    // Field widths fixed by the item formats.
    localparam int CW    = 12;  // vertex x and y
    localparam int ZW    = 16;  // vertex depth
    localparam int DW    = 24;  // Q16.8 depth
    localparam int COLW  = 24;  // colour
    localparam int XYW   = 3;   // pixel column and row

    // Internal arithmetic widths.
    localparam int EW    = CW + 1;      // coordinate differences
    localparam int PW    = 2 * EW;      // edge products
    localparam int UW    = PW + 1;      // edge terms and area
    localparam int NW    = UW + 3;      // barycentric numerators
    localparam int MW    = NW + ZW;     // weight times depth
    localparam int SW    = MW + 2;      // sum of three products
    localparam int NUMW  = SW + 8;      // numerator scaled by 256
    localparam int QW    = DW;          // quotient bits
    localparam int RW    = UW + 1;      // divider remainder
    localparam int CNTW  = $clog2(QW);

    localparam logic signed [DW-1:0] FAR_DEPTH = {1'b1, {(DW-1){1'b0}}};

    // Input item.
    typedef struct packed {
        logic                   kind;
        logic signed [CW-1:0]   ax;
        logic signed [CW-1:0]   ay;
        logic signed [ZW-1:0]   az;
        logic signed [CW-1:0]   bx;
        logic signed [CW-1:0]   by_coord;
        logic signed [ZW-1:0]   bz;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [ZW-1:0]   cz;
        logic [COLW-1:0]        fill_color;
    } t_tri;

    // Result item.
    typedef struct packed {
        logic [XYW-1:0]         pixel_x;
        logic [XYW-1:0]         pixel_y;
        logic signed [DW-1:0]   pixel_depth;
        logic [COLW-1:0]        pixel_color;
        logic                   last_pixel;
    } t_pix;

    // Item kinds.
    localparam logic KIND_DRAW  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP_MUL,
        S_SETUP_SUB,
        S_CHECK,
        S_PIX_MUL,
        S_PIX_SUM,
        S_Z_MUL,
        S_Z_SUM,
        S_DIV_LOAD,
        S_DIV,
        S_CMP,
        S_EMIT,
        S_ADV,
        S_FLUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic setup_mul;
        logic setup_sub;
        logic pix_mul;
        logic pix_sum;
        logic z_mul;
        logic z_sum;
        logic div_load;
        logic div_step;
        logic write;
        logic capture;
        logic push;
        logic push_last;
        logic adv;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic u2_zero;
        logic pix_ok;
        logic z_gt;
        logic scan_end;
        logic pend_valid;
        logic out_free;
        logic div_done;
    } t_stat;

endpackage

### rtl/tdr_if.sv
// Valid/ready channel interfaces for triangle items and pixel results.
interface tdr_tri_if;
    import tdr_pkg::*;
    logic valid;
    logic ready;
    tdr_pkg::t_tri data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdr_pix_if;
    import tdr_pkg::*;
    logic valid;
    logic ready;
    tdr_pkg::t_pix data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/tdr_ctrl.sv
// Controller state machine that sequences setup, the pixel scan and result transfers.
module tdr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_kind,
    input  tdr_pkg::t_stat  i_stat,
    output logic            o_ready,
    output tdr_pkg::t_cmd   o_cmd
);
    import tdr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (i_kind == KIND_DRAW)) n_state = S_SETUP_MUL;
            end
            S_SETUP_MUL: n_state = S_SETUP_SUB;
            S_SETUP_SUB: n_state = S_CHECK;
            S_CHECK:     n_state = i_stat.u2_zero ? S_IDLE : S_PIX_MUL;
            S_PIX_MUL:   n_state = S_PIX_SUM;
            S_PIX_SUM:   n_state = S_Z_MUL;
            S_Z_MUL:     n_state = i_stat.pix_ok ? S_Z_SUM : S_ADV;
            S_Z_SUM:     n_state = S_DIV_LOAD;
            S_DIV_LOAD:  n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) n_state = S_CMP;
            end
            S_CMP:       n_state = i_stat.z_gt ? S_EMIT : S_ADV;
            S_EMIT: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = S_ADV;
            end
            S_ADV:       n_state = i_stat.scan_end ? S_FLUSH : S_PIX_MUL;
            S_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.load  = i_valid && (i_kind == KIND_DRAW);
                o_cmd.clear = i_valid && (i_kind == KIND_CLEAR);
            end
            S_SETUP_MUL: o_cmd.setup_mul = 1'b1;
            S_SETUP_SUB: o_cmd.setup_sub = 1'b1;
            S_CHECK:     ;
            S_PIX_MUL:   o_cmd.pix_mul = 1'b1;
            S_PIX_SUM:   o_cmd.pix_sum = 1'b1;
            S_Z_MUL:     o_cmd.z_mul = 1'b1;
            S_Z_SUM:     o_cmd.z_sum = 1'b1;
            S_DIV_LOAD:  o_cmd.div_load = 1'b1;
            S_DIV:       o_cmd.div_step = 1'b1;
            S_CMP:       o_cmd.write = i_stat.z_gt;
            S_EMIT: begin
                o_cmd.capture = !i_stat.pend_valid || i_stat.out_free;
                o_cmd.push    = i_stat.pend_valid && i_stat.out_free;
            end
            S_ADV:       o_cmd.adv = 1'b1;
            S_FLUSH: begin
                o_cmd.push      = i_stat.pend_valid && i_stat.out_free;
                o_cmd.push_last = 1'b1;
            end
            default:     ;
        endcase
    end

endmodule

### rtl/tdr_datapath.sv
// Datapath: edge arithmetic, serial divider, depth store and result registers.
module tdr_datapath #(
    parameter int TILE_W = 8,
    parameter int TILE_H = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tdr_pkg::t_cmd   i_cmd,
    input  tdr_pkg::t_tri   i_tri_data,
    output tdr_pkg::t_stat  o_stat,
    tdr_pix_if.source       o_pix
);
    import tdr_pkg::*;

    localparam int NPIX = TILE_W * TILE_H;
    localparam int IW   = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam logic signed [CW-1:0] XMAX = CW'(TILE_W - 1);
    localparam logic signed [CW-1:0] YMAX = CW'(TILE_H - 1);

    function automatic logic signed [CW-1:0] f_min3(input logic signed [CW-1:0] a,
            input logic signed [CW-1:0] b, input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        return m;
    endfunction

    function automatic logic signed [CW-1:0] f_max3(input logic signed [CW-1:0] a,
            input logic signed [CW-1:0] b, input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

    function automatic logic [XYW-1:0] f_clamp(input logic signed [CW-1:0] v,
            input logic signed [CW-1:0] hi);
        logic signed [CW-1:0] c;
        c = v;
        if (c < 0) c = '0;
        if (c > hi) c = hi;
        return c[XYW-1:0];
    endfunction

    // Triangle registers.
    logic signed [CW-1:0]   r_ax, r_ay;
    logic signed [ZW-1:0]   r_az, r_bz, r_cz;
    logic signed [EW-1:0]   r_dxb, r_dyb, r_dxc, r_dyc;
    logic [COLW-1:0]        r_color;
    logic [XYW-1:0]         r_bx1, r_by0, r_by1, r_px, r_py;
    logic signed [PW-1:0]   r_p1, r_p2;
    logic signed [UW-1:0]   r_u2;
    logic [UW-1:0]          r_d;

    // Pixel registers.
    logic signed [PW-1:0]   r_m0, r_m1, r_m2, r_m3;
    logic signed [NW-1:0]   r_n0, r_n1, r_n2;
    logic                   r_ok;
    logic signed [MW-1:0]   r_s0, r_s1, r_s2;
    logic [NUMW-1:0]        r_absnum;
    logic                   r_neg;
    logic [RW-1:0]          r_rem;
    logic [QW-1:0]          r_quo;
    logic [CNTW-1:0]        r_cnt;

    // Depth store and its valid bits.
    logic signed [DW-1:0]   r_mem [NPIX];
    logic [NPIX-1:0]        r_vld;
    logic signed [DW-1:0]   r_rd;
    logic                   r_rd_vld;

    // Pending pixel and output register.
    t_pix                   r_pend;
    logic                   r_pend_valid;
    t_pix                   r_out;
    logic                   r_out_valid;

    logic signed [EW-1:0]   tx, ty;
    logic signed [UW-1:0]   u0, u1;
    logic signed [NW-1:0]   n0, n1, n2;
    logic signed [UW-1:0]   u2_next;
    logic signed [SW-1:0]   zsum;
    logic [SW-1:0]          zabs;
    logic [RW-1:0]          rem2;
    logic                   ge;
    logic signed [DW-1:0]   zmag, z, stored;
    logic [IW-1:0]          idx;
    logic                   out_free;

    assign tx      = EW'(r_ax) - EW'($signed({1'b0, r_px}));
    assign ty      = EW'(r_ay) - EW'($signed({1'b0, r_py}));
    assign u0      = UW'(r_m0) - UW'(r_m1);
    assign u1      = UW'(r_m2) - UW'(r_m3);
    assign u2_next = UW'(r_p1) - UW'(r_p2);
    assign idx     = IW'(r_py * TILE_W + r_px);
    assign out_free = !r_out_valid || o_pix.ready;

    // Barycentric numerators, sign-normalised so that the area is positive.
    always_comb begin
        n0 = NW'(r_u2) - NW'(u0) - NW'(u1);
        n1 = NW'(u1);
        n2 = NW'(u0);
        if (r_u2 < 0) begin
            n0 = -n0;
            n1 = -n1;
            n2 = -n2;
        end
    end

    assign zsum = SW'(r_s0) + SW'(r_s1) + SW'(r_s2);
    assign zabs = (zsum < 0) ? SW'(-zsum) : SW'(zsum);

    // One restoring division step.
    assign rem2 = {r_rem[RW-2:0], r_quo[QW-1]};
    assign ge   = rem2 >= {1'b0, r_d};

    assign zmag   = $signed(r_quo);
    assign z      = r_neg ? -zmag : zmag;
    assign stored = r_rd_vld ? r_rd : FAR_DEPTH;

    // Triangle setup and scan position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= i_tri_data.ax;
            r_ay    <= i_tri_data.ay;
            r_az    <= i_tri_data.az;
            r_bz    <= i_tri_data.bz;
            r_cz    <= i_tri_data.cz;
            r_dxb   <= EW'(i_tri_data.bx) - EW'(i_tri_data.ax);
            r_dyb   <= EW'(i_tri_data.by_coord) - EW'(i_tri_data.ay);
            r_dxc   <= EW'(i_tri_data.cx) - EW'(i_tri_data.ax);
            r_dyc   <= EW'(i_tri_data.cy) - EW'(i_tri_data.ay);
            r_color <= i_tri_data.fill_color;
            r_bx1   <= f_clamp(f_max3(i_tri_data.ax, i_tri_data.bx, i_tri_data.cx), XMAX);
            r_by0   <= f_clamp(f_min3(i_tri_data.ay, i_tri_data.by_coord, i_tri_data.cy),
                               YMAX);
            r_by1   <= f_clamp(f_max3(i_tri_data.ay, i_tri_data.by_coord, i_tri_data.cy),
                               YMAX);
            r_px    <= f_clamp(f_min3(i_tri_data.ax, i_tri_data.bx, i_tri_data.cx), XMAX);
            r_py    <= f_clamp(f_min3(i_tri_data.ay, i_tri_data.by_coord, i_tri_data.cy),
                               YMAX);
        end else if (i_cmd.adv) begin
            if (r_py == r_by1) begin
                r_py <= r_by0;
                r_px <= r_px + 1'b1;
            end else begin
                r_py <= r_py + 1'b1;
            end
        end
        if (i_cmd.setup_mul) begin
            r_p1 <= PW'(r_dxc * r_dyb);
            r_p2 <= PW'(r_dxb * r_dyc);
        end
        if (i_cmd.setup_sub) begin
            r_u2 <= u2_next;
            r_d  <= (u2_next < 0) ? UW'(-u2_next) : UW'(u2_next);
        end
    end

    // Per-pixel arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_mul) begin
            r_m0 <= PW'(r_dxb * ty);
            r_m1 <= PW'(tx * r_dyb);
            r_m2 <= PW'(tx * r_dyc);
            r_m3 <= PW'(r_dxc * ty);
        end
        if (i_cmd.pix_sum) begin
            r_n0 <= n0;
            r_n1 <= n1;
            r_n2 <= n2;
            r_ok <= (n0 >= 0) && (n1 >= 0) && (n2 >= 0);
        end
        if (i_cmd.z_mul) begin
            r_s0 <= MW'(r_n0 * r_az);
            r_s1 <= MW'(r_n1 * r_bz);
            r_s2 <= MW'(r_n2 * r_cz);
        end
        if (i_cmd.z_sum) begin
            r_neg    <= zsum < 0;
            r_absnum <= {zabs, 8'd0};
        end
    end

    // Serial divider, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= RW'(r_absnum >> QW);
            r_quo <= r_absnum[QW-1:0];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? (rem2 - {1'b0, r_d}) : rem2;
            r_quo <= {r_quo[QW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Depth store memory, read every cycle at the scan position.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[idx];
        if (i_cmd.write) r_mem[idx] <= z;
    end

    // Valid bits: an entry never written since a clear reads as the farthest depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[idx];
            if (i_cmd.clear) begin
                r_vld <= '0;
            end else if (i_cmd.write) begin
                r_vld[idx] <= 1'b1;
            end
        end
    end

    // Pending pixel holds one result back until it is known whether it is the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.push && i_cmd.push_last) begin
            r_pend_valid <= 1'b0;
        end
        if (i_cmd.capture) begin
            r_pend.pixel_x     <= r_px;
            r_pend.pixel_y     <= r_py;
            r_pend.pixel_depth <= z;
            r_pend.pixel_color <= r_color;
            r_pend.last_pixel  <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.push) begin
            r_out            <= r_pend;
            r_out.last_pixel <= i_cmd.push_last;
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

    assign o_stat.u2_zero    = (r_u2 == '0);
    assign o_stat.pix_ok     = r_ok;
    assign o_stat.z_gt       = z > stored;
    assign o_stat.scan_end   = (r_py == r_by1) && (r_px == r_bx1);
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;
    assign o_stat.div_done   = (r_cnt == CNTW'(QW - 1));

endmodule

### rtl/triangle_depth_rasterizer.sv
// Top level of the triangle rasterizer with a tile depth store.
//
// i_tri takes one item per transfer: a draw item (three vertices and a colour)
// or a clear item that resets every depth entry to the farthest value.
// o_pix gives one transfer per written pixel; the last pixel of a triangle carries
// last_pixel. A triangle that writes nothing gives no transfer at all.
// Items are worked one at a time; i_tri.ready is high only while the block is idle.
// A draw item passes through setup after its transfer, then for each pixel of the
// clamped bounding box forms the edge terms; a pixel outside the triangle is skipped,
// and a pixel inside it has its depth formed by the 24-step serial divider. A final
// flush step then sends the last pending pixel.
// Results are held one behind in a pending register so the last one can be marked,
// then pass through an output register; a stalled receiver holds the output
// register and the scan waits only when a second result needs the slot.
// Reset (synchronous, active low) empties the output and marks every depth
// entry as farthest.
module triangle_depth_rasterizer #(
    parameter int TILE_W = 8,
    parameter int TILE_H = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdr_tri_if.sink     i_tri,
    tdr_pix_if.source   o_pix
);
    import tdr_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ready;

    assign i_tri.ready = ready;

    tdr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_tri.valid),
        .i_kind  (i_tri.data.kind),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    tdr_datapath #(
        .TILE_W (TILE_W),
        .TILE_H (TILE_H)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_tri_data (i_tri.data),
        .o_stat     (stat),
        .o_pix      (o_pix)
    );

endmodule

### rtl/tdr_checker.sv
// Port-level checks for the triangle rasterizer and their attachment to the top level.
module tdr_checker #(
    parameter int TILE_W = 8,
    parameter int TILE_H = 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_in_kind,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input tdr_pkg::t_pix        i_out_data
);
    import tdr_pkg::*;

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // Results lie inside the tile.
    a_in_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_data.pixel_x) < TILE_W) &&
                        (32'(i_out_data.pixel_y) < TILE_H))
        else $error("result outside tile");

    // A clear is done in the cycle of its transfer.
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_CLEAR) |=> i_in_ready)
        else $error("busy after clear");

    // A draw transfer makes the block busy.
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_DRAW) |=> !i_in_ready)
        else $error("ready after draw");

endmodule

bind triangle_depth_rasterizer tdr_checker #(
    .TILE_W (TILE_W),
    .TILE_H (TILE_H)
) u_tdr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tri.valid),
    .i_in_ready  (i_tri.ready),
    .i_in_kind   (i_tri.data.kind),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);
